### sv/dtd_pkg.sv
// Package for the delayed task dispatcher: request kinds, sequencer states,
// fixed field widths and the verdict that the slot unit hands the sequencer.
// No dependencies.
`default_nettype none

package dtd_pkg;

  // Fixed widths of the port fields.
  localparam int TASK_PORT_W  = 8;
  localparam int DELAY_W      = 16;
  localparam int COUNT_PORT_W = 4;
  localparam int TICK_W       = 32;

  // Request kinds carried on in_kind.
  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_SET  = 2'd1,
    KIND_DISP = 2'd2,
    KIND_TICK = 2'd3
  } kind_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_POP    = 2'd2,
    ST_FINISH = 2'd3
  } state_t;

  // What the shared slot unit decides about one timer slot.
  typedef struct packed {
    logic               match;
    logic               free;
    logic               expire;
    logic [DELAY_W-1:0] rem_dec;
  } slot_verdict_t;

endpackage

`default_nettype wire

### sv/dtd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module dtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/dtd_slot_unit.sv
// Shared compare and decrement unit applied to one timer slot per cycle.
// Depends on dtd_pkg.
`default_nettype none

module dtd_slot_unit #(
  parameter int TASK_ID_BITS = 8
) (
  input  wire logic                            slot_valid,
  input  wire logic [TASK_ID_BITS-1:0]         slot_task,
  input  wire logic [dtd_pkg::DELAY_W-1:0]     slot_rem,
  input  wire logic [TASK_ID_BITS-1:0]         req_id,
  output dtd_pkg::slot_verdict_t               verdict
);

  // A slot matches when it is occupied by the requested task; it expires
  // when its countdown stands at one. Every other occupied slot counts down.
  always_comb begin
    verdict.match   = slot_valid && (slot_task == req_id);
    verdict.free    = !slot_valid;
    verdict.expire  = slot_valid && (slot_rem == dtd_pkg::DELAY_W'(1));
    verdict.rem_dec = slot_rem - dtd_pkg::DELAY_W'(1);
  end

endmodule

`default_nettype wire

### sv/delayed_task_dispatcher_core.sv
// Top level of the delayed task dispatcher: sequencer, ready queue and timer table.
// Depends on dtd_pkg, dtd_ram and dtd_slot_unit.
//
//   channel  | ports                                          | handshake
//   ---------+------------------------------------------------+-----------------------
//   request  | in_kind, in_task_id, in_delay                  | start high, busy low
//   result   | out_dispatched_task, out_status,               | out_valid, one cycle,
//            | out_queue_count, out_tick_count                | no backpressure
//
// After the accepting edge busy stays high through FINISH alone (enqueue, or set
// timer for the idle task), through POP and FINISH (dispatch, one queue memory
// read) or through SCAN and FINISH (set timer, tick): the timer table has one
// read port and is scanned one slot per cycle, with one slot read ahead. A set timer
// that finds its task stops the scan early. The result strobe comes in the
// cycle busy falls, and a new request may be taken in that same cycle.
// rst_n is synchronous, active low; it empties the queue and the timer table.
// The receiver cannot stall, so a result is shown exactly once.
`default_nettype none

module delayed_task_dispatcher_core #(
  parameter int QUEUE_SLOTS  = 8,
  parameter int TIMER_SLOTS  = 8,
  parameter int TASK_ID_BITS = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [1:0]                           in_kind,
  input  wire logic [dtd_pkg::TASK_PORT_W-1:0]      in_task_id,
  input  wire logic [dtd_pkg::DELAY_W-1:0]          in_delay,
  output logic                                      out_valid,
  output logic      [dtd_pkg::TASK_PORT_W-1:0]      out_dispatched_task,
  output logic                                      out_status,
  output logic      [dtd_pkg::COUNT_PORT_W-1:0]     out_queue_count,
  output logic      [dtd_pkg::TICK_W-1:0]           out_tick_count
);

  localparam int QI = $clog2(QUEUE_SLOTS);
  localparam int QC = $clog2(QUEUE_SLOTS + 1);
  localparam int TI = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int TC = $clog2(TIMER_SLOTS + 1);
  localparam int TW = TASK_ID_BITS + dtd_pkg::DELAY_W;

  // Sequencer and request registers.
  dtd_pkg::state_t               state_r, state_nxt;
  dtd_pkg::kind_t                kind_r, kind_nxt;
  logic [TASK_ID_BITS-1:0]       id_r, id_nxt;
  logic [dtd_pkg::DELAY_W-1:0]   delay_r, delay_nxt;

  // Ready queue pointers.
  logic [QI-1:0]                 head_r, head_nxt;
  logic [QI-1:0]                 tail_r, tail_nxt;
  logic [QC-1:0]                 count_r, count_nxt;

  // Timer table occupancy and scan state.
  logic [TIMER_SLOTS-1:0]        valid_r, valid_nxt;
  logic [TC-1:0]                 rd_cnt_r, rd_cnt_nxt;
  logic                          pv_r, pv_nxt;
  logic [TI-1:0]                 pidx_r, pidx_nxt;
  logic                          free_found_r, free_found_nxt;
  logic [TI-1:0]                 free_idx_r, free_idx_nxt;
  logic                          done_r, done_nxt;
  logic                          dropped_r, dropped_nxt;

  logic [dtd_pkg::TICK_W-1:0]    tick_r, tick_nxt;

  // Result registers.
  logic                              out_valid_r, out_valid_nxt;
  logic [dtd_pkg::TASK_PORT_W-1:0]   out_disp_r, out_disp_nxt;
  logic                              out_status_r, out_status_nxt;
  logic [dtd_pkg::COUNT_PORT_W-1:0]  out_count_r, out_count_nxt;
  logic [dtd_pkg::TICK_W-1:0]        out_tick_r, out_tick_nxt;

  // Memory ports.
  logic                          q_we;
  logic [TASK_ID_BITS-1:0]       q_wdata, q_rdata;
  logic                          t_we;
  logic [TI-1:0]                 t_waddr;
  logic [TW-1:0]                 t_wdata, t_rdata;

  logic [TASK_ID_BITS-1:0]       slot_task;
  logic [dtd_pkg::DELAY_W-1:0]   slot_rem;
  logic                          slot_valid;
  logic                          scan_end;
  logic [TASK_ID_BITS-1:0]       in_id;
  dtd_pkg::slot_verdict_t        verdict;

  assign in_id      = TASK_ID_BITS'(in_task_id);
  assign slot_task  = t_rdata[TW-1:dtd_pkg::DELAY_W];
  assign slot_rem   = t_rdata[dtd_pkg::DELAY_W-1:0];
  assign slot_valid = valid_r[pidx_r];

  // Ready queue storage, read at the head.
  dtd_ram #(
    .WIDTH (TASK_ID_BITS),
    .DEPTH (QUEUE_SLOTS)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail_r),
    .wdata (q_wdata),
    .raddr (head_r),
    .rdata (q_rdata)
  );

  // Timer table storage: task id above, countdown below.
  dtd_ram #(
    .WIDTH (TW),
    .DEPTH (TIMER_SLOTS)
  ) u_timer_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (rd_cnt_r[TI-1:0]),
    .rdata (t_rdata)
  );

  // Shared compare and decrement unit.
  dtd_slot_unit #(
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_slot_unit (
    .slot_valid (slot_valid),
    .slot_task  (slot_task),
    .slot_rem   (slot_rem),
    .req_id     (id_r),
    .verdict    (verdict)
  );

  // The scan ends on the last slot, or when a set timer finds its task.
  assign scan_end = pv_r && ((rd_cnt_r == TC'(TIMER_SLOTS)) ||
                             ((kind_r == dtd_pkg::KIND_SET) && verdict.match));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dtd_pkg::ST_IDLE: begin
        if (start) begin
          case (dtd_pkg::kind_t'(in_kind))
            dtd_pkg::KIND_ENQ:  state_nxt = dtd_pkg::ST_FINISH;
            dtd_pkg::KIND_SET:  state_nxt = (in_id == '0) ? dtd_pkg::ST_FINISH
                                                          : dtd_pkg::ST_SCAN;
            dtd_pkg::KIND_DISP: state_nxt = dtd_pkg::ST_POP;
            dtd_pkg::KIND_TICK: state_nxt = dtd_pkg::ST_SCAN;
            default:            state_nxt = dtd_pkg::ST_IDLE;
          endcase
        end
      end
      dtd_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_nxt = dtd_pkg::ST_FINISH;
        end
      end
      dtd_pkg::ST_POP:    state_nxt = dtd_pkg::ST_FINISH;
      dtd_pkg::ST_FINISH: state_nxt = dtd_pkg::ST_IDLE;
      default:            state_nxt = dtd_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    kind_nxt       = kind_r;
    id_nxt         = id_r;
    delay_nxt      = delay_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    valid_nxt      = valid_r;
    rd_cnt_nxt     = rd_cnt_r;
    pv_nxt         = 1'b0;
    pidx_nxt       = pidx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    done_nxt       = done_r;
    dropped_nxt    = dropped_r;
    tick_nxt       = tick_r;
    out_valid_nxt  = 1'b0;
    out_disp_nxt   = out_disp_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_tick_nxt   = out_tick_r;
    q_we           = 1'b0;
    q_wdata        = id_r;
    t_we           = 1'b0;
    t_waddr        = pidx_r;
    t_wdata        = {id_r, delay_r};

    case (state_r)
      dtd_pkg::ST_IDLE: begin
        // Capture the request and clear the per-request flags.
        if (start) begin
          kind_nxt       = dtd_pkg::kind_t'(in_kind);
          id_nxt         = in_id;
          delay_nxt      = in_delay;
          rd_cnt_nxt     = '0;
          free_found_nxt = 1'b0;
          done_nxt       = 1'b0;
          dropped_nxt    = 1'b0;
          if (dtd_pkg::kind_t'(in_kind) == dtd_pkg::KIND_TICK) begin
            tick_nxt = tick_r + dtd_pkg::TICK_W'(1);
          end
        end
      end

      dtd_pkg::ST_SCAN: begin
        // Read ahead one slot while the previous one is processed.
        if (rd_cnt_r != TC'(TIMER_SLOTS)) begin
          pv_nxt     = 1'b1;
          pidx_nxt   = rd_cnt_r[TI-1:0];
          rd_cnt_nxt = rd_cnt_r + TC'(1);
        end
        if (pv_r) begin
          if (kind_r == dtd_pkg::KIND_TICK) begin
            if (verdict.expire) begin
              // The slot frees itself; its task goes to the queue if room.
              valid_nxt[pidx_r] = 1'b0;
              if (count_r == QC'(QUEUE_SLOTS)) begin
                dropped_nxt = 1'b1;
              end else begin
                q_we      = 1'b1;
                q_wdata   = slot_task;
                tail_nxt  = (tail_r == QI'(QUEUE_SLOTS - 1)) ? '0 : tail_r + QI'(1);
                count_nxt = count_r + QC'(1);
              end
            end else if (slot_valid) begin
              t_we    = 1'b1;
              t_wdata = {slot_task, verdict.rem_dec};
            end
          end else begin
            // Set timer: overwrite a matching slot, else note the first free one.
            if (verdict.match) begin
              t_we     = 1'b1;
              done_nxt = 1'b1;
            end else if (verdict.free && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_idx_nxt   = pidx_r;
            end
          end
        end
      end

      dtd_pkg::ST_POP: begin
        // The queue memory reads the head during this cycle.
      end

      dtd_pkg::ST_FINISH: begin
        out_status_nxt = dropped_r;
        out_disp_nxt   = '0;
        case (kind_r)
          dtd_pkg::KIND_ENQ: begin
            if (id_r != '0) begin
              if (count_r == QC'(QUEUE_SLOTS)) begin
                out_status_nxt = 1'b1;
              end else begin
                q_we      = 1'b1;
                tail_nxt  = (tail_r == QI'(QUEUE_SLOTS - 1)) ? '0 : tail_r + QI'(1);
                count_nxt = count_r + QC'(1);
              end
            end
          end
          dtd_pkg::KIND_SET: begin
            // A set timer for the idle task is ignored without a drop.
            if (!done_r && (id_r != '0)) begin
              if (free_found_r) begin
                t_we                  = 1'b1;
                t_waddr               = free_idx_r;
                valid_nxt[free_idx_r] = 1'b1;
              end else begin
                out_status_nxt = 1'b1;
              end
            end
          end
          dtd_pkg::KIND_DISP: begin
            if (count_r != '0) begin
              out_disp_nxt = dtd_pkg::TASK_PORT_W'(q_rdata);
              head_nxt     = (head_r == QI'(QUEUE_SLOTS - 1)) ? '0 : head_r + QI'(1);
              count_nxt    = count_r - QC'(1);
            end
          end
          dtd_pkg::KIND_TICK: begin
          end
          default: begin
          end
        endcase
        out_valid_nxt = 1'b1;
        out_count_nxt = dtd_pkg::COUNT_PORT_W'(count_nxt);
        out_tick_nxt  = tick_r;
      end

      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dtd_pkg::ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      valid_r     <= '0;
      rd_cnt_r    <= '0;
      pv_r        <= 1'b0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      valid_r     <= valid_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      pv_r        <= pv_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    id_r         <= id_nxt;
    delay_r      <= delay_nxt;
    pidx_r       <= pidx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    done_r       <= done_nxt;
    dropped_r    <= dropped_nxt;
    out_disp_r   <= out_disp_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_tick_r   <= out_tick_nxt;
  end

  // Port drive.
  assign busy                = (state_r != dtd_pkg::ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_dispatched_task = out_disp_r;
  assign out_status          = out_status_r;
  assign out_queue_count     = out_count_r;
  assign out_tick_count      = out_tick_r;

endmodule

`default_nettype wire

### sv/dtd_checker.sv
// Port-level checks for the delayed task dispatcher, bound to the top level.
// Depends on delayed_task_dispatcher_core.
`default_nettype none

module dtd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic [7:0] out_dispatched_task,
  input wire logic       out_status
);

  // An accepted request makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // A result appears only once the block is free again.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // Each request yields exactly one strobe, never two in a row.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // A dispatched task never comes with a dropped request.
  a_dispatch_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_dispatched_task != 8'd0) |-> !out_status)
    else $error("dispatch reported a drop");

endmodule

bind delayed_task_dispatcher_core dtd_checker u_dtd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_dispatched_task (out_dispatched_task),
  .out_status          (out_status)
);

`default_nettype wire

### test/tb.sv
// Self-checking testbench for delayed_task_dispatcher_core: directed corner cases, then
// random request mixes checked against an in-bench scheduler predictor.
// Depends on dtd_pkg and the delayed_task_dispatcher_core RTL.
module tb;
  import dtd_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int QUEUE_DEPTH = 8;
  localparam int TIMER_COUNT = 8;
  localparam int MAX_REPORTS = 10;

  // One result as the block reports it.
  typedef struct packed {
    logic [TASK_PORT_W-1:0]  popped;
    logic                    dropped;
    logic [COUNT_PORT_W-1:0] depth;
    logic [TICK_W-1:0]       ticks;
  } step_result_t;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              in_kind = KIND_ENQ;
  logic [TASK_PORT_W-1:0]  in_task_id = '0;
  logic [DELAY_W-1:0]      in_delay = '0;
  logic                    out_valid;
  logic [TASK_PORT_W-1:0]  out_dispatched_task;
  logic                    out_status;
  logic [COUNT_PORT_W-1:0] out_queue_count;
  logic [TICK_W-1:0]       out_tick_count;

  // Predictor copy of the scheduler state.
  logic [TASK_PORT_W-1:0] ready_tasks [QUEUE_DEPTH];
  int                     ready_head;
  int                     ready_len;
  logic [TASK_PORT_W-1:0] timer_owner [TIMER_COUNT];
  logic [DELAY_W-1:0]     timer_left  [TIMER_COUNT];
  logic [TICK_W-1:0]      tick_total;

  step_result_t predicted_results [$];
  bit           no_gaps;
  int           fault_count;
  int           sent_count;
  int           checked_count;
  int           drop_count;
  int           fire_count;
  int           empty_pop_count;

  delayed_task_dispatcher_core #(
    .QUEUE_SLOTS (QUEUE_DEPTH),
    .TIMER_SLOTS (TIMER_COUNT),
    .TASK_ID_BITS(TASK_PORT_W)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_task_id         (in_task_id),
    .in_delay           (in_delay),
    .out_valid          (out_valid),
    .out_dispatched_task(out_dispatched_task),
    .out_status         (out_status),
    .out_queue_count    (out_queue_count),
    .out_tick_count     (out_tick_count)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(CLK_PERIOD * 400000);
    $display("FAIL");
    $finish;
  end

  task automatic report_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  // Appends a task to the ready queue; returns 1 when the queue is full.
  function automatic logic queue_push(input logic [TASK_PORT_W-1:0] id);
    if (id == '0) begin
      return 1'b0;
    end
    if (ready_len >= QUEUE_DEPTH) begin
      return 1'b1;
    end
    ready_tasks[(ready_head + ready_len) % QUEUE_DEPTH] = id;
    ready_len++;
    return 1'b0;
  endfunction

  // Applies one request to the predicted state and returns the expected result.
  function automatic step_result_t schedule_step(input kind_t kind,
                                                 input logic [TASK_PORT_W-1:0] id,
                                                 input logic [DELAY_W-1:0] dly);
    step_result_t r;
    int           slot;
    r = '0;
    case (kind)
      KIND_ENQ: begin
        r.dropped = queue_push(id);
      end
      KIND_SET: begin
        if (id != '0) begin
          // A slot that already holds the task wins over the first free one.
          slot = -1;
          for (int i = 0; i < TIMER_COUNT; i++) begin
            if (slot < 0 && timer_owner[i] == id) slot = i;
          end
          for (int i = 0; i < TIMER_COUNT; i++) begin
            if (slot < 0 && timer_owner[i] == '0) slot = i;
          end
          if (slot < 0) begin
            r.dropped = 1'b1;
          end else begin
            timer_owner[slot] = id;
            timer_left[slot]  = dly;
          end
        end
      end
      KIND_DISP: begin
        if (ready_len != 0) begin
          r.popped = ready_tasks[ready_head];
          ready_tasks[ready_head] = '0;
          ready_head = (ready_head + 1) % QUEUE_DEPTH;
          ready_len--;
        end else begin
          empty_pop_count++;
        end
      end
      default: begin
        // Slots are scanned in index order; a countdown of one fires the task.
        tick_total = tick_total + 1'b1;
        for (int i = 0; i < TIMER_COUNT; i++) begin
          if (timer_owner[i] != '0) begin
            if (timer_left[i] != 16'd1) begin
              timer_left[i] = timer_left[i] - 1'b1;
            end else begin
              if (queue_push(timer_owner[i])) r.dropped = 1'b1;
              timer_owner[i] = '0;
              fire_count++;
            end
          end
        end
      end
    endcase
    if (r.dropped) drop_count++;
    r.depth = COUNT_PORT_W'(ready_len);
    r.ticks = tick_total;
    return r;
  endfunction

  // Sends one request after a random gap and records its expected result.
  task automatic send_request(input kind_t kind, input logic [TASK_PORT_W-1:0] id,
                              input logic [DELAY_W-1:0] dly);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_kind    <= kind;
    in_task_id <= id;
    in_delay   <= dly;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted_results.push_back(schedule_step(kind, id, dly));
    sent_count++;
  endtask

  // Holds requests off until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (predicted_results.size() != 0);
  endtask

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin : check_results
    step_result_t seen;
    step_result_t want;
    if (rst_n && out_valid) begin
      seen = {out_dispatched_task, out_status, out_queue_count, out_tick_count};
      if (predicted_results.size() == 0) begin
        report_fault($sformatf("unexpected result task=%0d status=%0d count=%0d ticks=%0d",
                               seen.popped, seen.dropped, seen.depth, seen.ticks));
      end else begin
        want = predicted_results.pop_front();
        checked_count++;
        if (seen.popped !== want.popped || seen.dropped !== want.dropped ||
            seen.depth !== want.depth || seen.ticks !== want.ticks) begin
          report_fault($sformatf({"result mismatch: task exp %0d act %0d, status exp %0d ",
                                  "act %0d, count exp %0d act %0d, ticks exp %0d act %0d"},
                                 want.popped, seen.popped, want.dropped, seen.dropped,
                                 want.depth, seen.depth, want.ticks, seen.ticks));
        end
      end
    end
  end

  // Corner cases: empty pop, idle ids, full queue, rearm, expiry into a full
  // queue, zero delay wrapping to the top of the countdown.
  task automatic test_directed_cases();
    send_request(KIND_DISP, 8'd0, 16'd0);
    send_request(KIND_ENQ, 8'd0, 16'd0);
    send_request(KIND_ENQ, 8'd255, 16'd0);
    for (int b = 0; b < 7; b++) begin
      send_request(KIND_ENQ, 8'(1 << b), 16'd0);
    end
    send_request(KIND_ENQ, 8'd128, 16'hFFFF);
    send_request(KIND_SET, 8'd0, 16'd5);
    send_request(KIND_SET, 8'h55, 16'hFFFF);
    send_request(KIND_SET, 8'h55, 16'd1);
    send_request(KIND_TICK, 8'd0, 16'd0);
    send_request(KIND_SET, 8'hAA, 16'd0);
    send_request(KIND_DISP, 8'd0, 16'd0);
    send_request(KIND_SET, 8'h0F, 16'd1);
    send_request(KIND_TICK, 8'hFF, 16'hFFFF);
    send_request(KIND_DISP, 8'd0, 16'd0);
    send_request(KIND_DISP, 8'd0, 16'd0);
    send_request(KIND_SET, 8'hAA, 16'd1);
    send_request(KIND_TICK, 8'd0, 16'd0);
  endtask

  // Arms more timers than the table holds, then lets them all expire.
  task automatic test_timer_table_full();
    for (int n = 0; n < QUEUE_DEPTH + 1; n++) begin
      send_request(KIND_DISP, 8'd0, 16'd0);
    end
    for (int n = 0; n < TIMER_COUNT + 2; n++) begin
      send_request(KIND_SET, 8'(100 + n * 13), 16'($urandom_range(2, 6)));
    end
    for (int n = 0; n < 7; n++) begin
      send_request(KIND_TICK, 8'($urandom), 16'($urandom));
    end
    for (int n = 0; n < QUEUE_DEPTH + 1; n++) begin
      send_request(KIND_DISP, 8'd0, 16'd0);
    end
  endtask

  // Random request mix; pop_pct sets how hard the ready queue is drained.
  task automatic test_random_mix(input int unsigned count, input int unsigned pop_pct);
    kind_t                  kind;
    logic [TASK_PORT_W-1:0] id;
    logic [DELAY_W-1:0]     dly;
    int unsigned            pick;
    for (int n = 0; n < count; n++) begin
      // Switch between back-to-back bursts and gappy traffic.
      if (n % 120 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      kind = (pick < 22) ? KIND_ENQ :
             (pick < 47) ? KIND_SET :
             (pick < 47 + pop_pct) ? KIND_DISP : KIND_TICK;
      pick = $urandom_range(0, 99);
      id = (pick < 5)  ? 8'd0 :
           (pick < 70) ? 8'($urandom_range(1, 12)) : 8'($urandom_range(1, 255));
      pick = $urandom_range(0, 99);
      dly = (pick < 5)  ? 16'd0 :
            (pick < 10) ? 16'hFFFF :
            (pick < 16) ? 16'($urandom) : 16'($urandom_range(1, 24));
      // Long countdowns only on the small id pool, which gets rearmed often.
      if (id > 8'd12) dly = 16'($urandom_range(1, 24));
      send_request(kind, id, dly);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    no_gaps = 1'b0;
    test_directed_cases();
    drain_results();
    test_timer_table_full();
    drain_results();
    test_random_mix(420, 20);
    drain_results();
    test_random_mix(420, 8);
    drain_results();
    test_random_mix(420, 33);
    drain_results();
    repeat (TIMER_COUNT + 8) @(posedge clk);

    $display("Sent %0d requests, checked %0d results.", sent_count, checked_count);
    $display("Saw %0d timer expiries, %0d drops and %0d pops of an empty queue.",
             fire_count, drop_count, empty_pop_count);
    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d failures.", fault_count);
      $display("FAIL");
    end
    $finish;
  end

endmodule
